// ===== src/yrgb_pkg.sv =====
// Shared types and constants for the YCbCr to RGB pixel converter.
// No dependencies; every other file in src refers to this package by scoped names.
package yrgb_pkg;

  // Source format codes held in the configuration register
  localparam logic FMT_PACKED = 1'b0;  // 4:2:2 pair, two pixels per request
  localparam logic FMT_BLOCK  = 1'b1;  // 4:2:0 two by two block, four pixels

  // Final pixel index of a request in each format
  localparam logic [1:0] LAST_IDX_PACKED = 2'd1;
  localparam logic [1:0] LAST_IDX_BLOCK  = 2'd3;

  localparam int PROD_W = 18;  // coefficient products
  localparam int SUM_W  = 20;  // rounded component sums

  localparam logic [8:0] LUMA_OFS   = 9'd16;
  localparam logic [8:0] CHROMA_OFS = 9'd128;

  localparam logic signed [PROD_W-1:0] COEF_Y  = 18'sd298;
  localparam logic signed [PROD_W-1:0] COEF_RE = 18'sd409;
  localparam logic signed [PROD_W-1:0] COEF_GD = 18'sd100;
  localparam logic signed [PROD_W-1:0] COEF_GE = 18'sd208;
  localparam logic signed [PROD_W-1:0] COEF_BD = 18'sd516;
  localparam logic signed [SUM_W-1:0]  ROUND   = 20'sd128;

  localparam logic [7:0] ALPHA_PACKED = 8'hFF;
  localparam logic [7:0] ALPHA_BLOCK  = 8'h00;
  localparam logic [7:0] COMP_MAX     = 8'hFF;
  localparam logic [7:0] COMP_MIN     = 8'h00;

  typedef struct packed {
    logic [7:0] luma0;
    logic [7:0] luma1;
    logic [7:0] luma2;
    logic [7:0] luma3;
    logic [7:0] chroma_blue;
    logic [7:0] chroma_red;
  } in_item_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       lower_row;
    logic       column;
    logic       last_of_item;
  } out_item_t;

  // Per-pixel tags that ride along the pipeline
  typedef struct packed {
    logic blk;
    logic lower_row;
    logic column;
    logic last;
  } tag_t;

  typedef struct packed {
    logic              valid;
    tag_t              tag;
    logic signed [8:0] c;
    logic signed [8:0] d;
    logic signed [8:0] e;
  } stage1_t;

  typedef struct packed {
    logic                     valid;
    tag_t                     tag;
    logic signed [PROD_W-1:0] yc;
    logic signed [PROD_W-1:0] re;
    logic signed [PROD_W-1:0] gd;
    logic signed [PROD_W-1:0] ge;
    logic signed [PROD_W-1:0] bd;
  } stage2_t;

  typedef struct packed {
    logic                    valid;
    tag_t                    tag;
    logic signed [SUM_W-1:0] r;
    logic signed [SUM_W-1:0] g;
    logic signed [SUM_W-1:0] b;
  } stage3_t;

endpackage

// ===== src/yrgb_issue.sv =====
// Request holder and pixel issue stage: splits one request into pixels, one per cycle.
// Depends on yrgb_pkg.
module yrgb_issue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              fmt,
  input  yrgb_pkg::in_item_t in_item,
  output logic              busy,
  output yrgb_pkg::stage1_t s1
);

  yrgb_pkg::in_item_t item_r;
  logic               blk_r;
  logic               act_r;
  logic [1:0]         idx_r;
  logic [1:0]         idx_nxt;
  logic               act_nxt;
  logic               is_last;
  logic               accept;
  logic [7:0]         luma_sel;
  yrgb_pkg::stage1_t  s1_r;
  yrgb_pkg::stage1_t  s1_nxt;

  assign is_last = blk_r ? (idx_r == yrgb_pkg::LAST_IDX_BLOCK)
                         : (idx_r == yrgb_pkg::LAST_IDX_PACKED);
  // Free again in the cycle the final pixel issues
  assign busy    = act_r && !is_last;
  assign accept  = start && !busy;

  always_comb begin
    unique case (idx_r)
      2'd0:    luma_sel = item_r.luma0;
      2'd1:    luma_sel = item_r.luma1;
      2'd2:    luma_sel = item_r.luma2;
      default: luma_sel = item_r.luma3;
    endcase
  end

  always_comb begin
    act_nxt = act_r;
    idx_nxt = idx_r;
    priority if (accept) begin
      act_nxt = 1'b1;
      idx_nxt = 2'd0;
    end else if (act_r && is_last) begin
      act_nxt = 1'b0;
    end else if (act_r) begin
      idx_nxt = idx_r + 2'd1;
    end
  end

  always_comb begin
    s1_nxt.valid         = act_r;
    s1_nxt.tag.blk       = blk_r;
    s1_nxt.tag.lower_row = idx_r[1];
    s1_nxt.tag.column    = idx_r[0];
    s1_nxt.tag.last      = is_last;
    s1_nxt.c = $signed({1'b0, luma_sel} - yrgb_pkg::LUMA_OFS);
    s1_nxt.d = $signed({1'b0, item_r.chroma_blue} - yrgb_pkg::CHROMA_OFS);
    s1_nxt.e = $signed({1'b0, item_r.chroma_red} - yrgb_pkg::CHROMA_OFS);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= 1'b0;
      idx_r <= 2'd0;
    end else begin
      act_r <= act_nxt;
      idx_r <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_item;
      blk_r  <= fmt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r.valid <= 1'b0;
    end else begin
      s1_r <= s1_nxt;
    end
  end

  assign s1 = s1_r;

endmodule

// ===== src/yrgb_arith.sv =====
// Matrix stages: coefficient products, then the three rounded component sums.
// Depends on yrgb_pkg.
module yrgb_arith (
  input  logic              clk,
  input  logic              rst_n,
  input  yrgb_pkg::stage1_t s1,
  output yrgb_pkg::stage3_t s3
);

  yrgb_pkg::stage2_t s2_r;
  yrgb_pkg::stage2_t s2_nxt;
  yrgb_pkg::stage3_t s3_r;
  yrgb_pkg::stage3_t s3_nxt;

  always_comb begin
    s2_nxt.valid = s1.valid;
    s2_nxt.tag   = s1.tag;
    s2_nxt.yc = yrgb_pkg::PROD_W'(yrgb_pkg::PROD_W'(s1.c) * yrgb_pkg::COEF_Y);
    s2_nxt.re = yrgb_pkg::PROD_W'(yrgb_pkg::PROD_W'(s1.e) * yrgb_pkg::COEF_RE);
    s2_nxt.gd = yrgb_pkg::PROD_W'(yrgb_pkg::PROD_W'(s1.d) * yrgb_pkg::COEF_GD);
    s2_nxt.ge = yrgb_pkg::PROD_W'(yrgb_pkg::PROD_W'(s1.e) * yrgb_pkg::COEF_GE);
    s2_nxt.bd = yrgb_pkg::PROD_W'(yrgb_pkg::PROD_W'(s1.d) * yrgb_pkg::COEF_BD);
  end

  always_comb begin
    s3_nxt.valid = s2_r.valid;
    s3_nxt.tag   = s2_r.tag;
    s3_nxt.r = yrgb_pkg::SUM_W'(s2_r.yc) + yrgb_pkg::SUM_W'(s2_r.re) + yrgb_pkg::ROUND;
    s3_nxt.g = yrgb_pkg::SUM_W'(s2_r.yc) - yrgb_pkg::SUM_W'(s2_r.gd)
             - yrgb_pkg::SUM_W'(s2_r.ge) + yrgb_pkg::ROUND;
    s3_nxt.b = yrgb_pkg::SUM_W'(s2_r.yc) + yrgb_pkg::SUM_W'(s2_r.bd) + yrgb_pkg::ROUND;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_r.valid <= 1'b0;
      s3_r.valid <= 1'b0;
    end else begin
      s2_r <= s2_nxt;
      s3_r <= s3_nxt;
    end
  end

  assign s3 = s3_r;

endmodule

// ===== src/yrgb_clamp.sv =====
// Output stage: shift, clamp to 0..255, alpha and tags, registered pixel and strobe.
// Depends on yrgb_pkg.
module yrgb_clamp (
  input  logic                clk,
  input  logic                rst_n,
  input  yrgb_pkg::stage3_t   s3,
  output logic                strobe,
  output yrgb_pkg::out_item_t pixel
);

  logic                strobe_r;
  yrgb_pkg::out_item_t pixel_r;
  yrgb_pkg::out_item_t pixel_nxt;

  function automatic logic [7:0] clamp8(input logic signed [yrgb_pkg::SUM_W-1:0] s);
    logic [7:0] v;
    begin
      priority if (s[yrgb_pkg::SUM_W-1]) begin
        v = yrgb_pkg::COMP_MIN;
      end else if (|s[yrgb_pkg::SUM_W-2:16]) begin
        v = yrgb_pkg::COMP_MAX;
      end else begin
        v = s[15:8];
      end
      return v;
    end
  endfunction

  always_comb begin
    pixel_nxt.red          = clamp8(s3.r);
    pixel_nxt.green        = clamp8(s3.g);
    pixel_nxt.blue         = clamp8(s3.b);
    pixel_nxt.alpha        = s3.tag.blk ? yrgb_pkg::ALPHA_BLOCK : yrgb_pkg::ALPHA_PACKED;
    pixel_nxt.lower_row    = s3.tag.lower_row;
    pixel_nxt.column       = s3.tag.column;
    pixel_nxt.last_of_item = s3.tag.last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= s3.valid;
    end
  end

  always_ff @(posedge clk) begin
    pixel_r <= pixel_nxt;
  end

  assign strobe = strobe_r;
  assign pixel  = pixel_r;

endmodule

// ===== src/ycbcr_to_rgb_pixel_converter.sv =====
// Pixels pass the c/d/e, product, sum and output registers in turn and follow one a cycle.
// In packed 4:2:2 mode a request gives two pixels, in 4:2:0 block mode four, all through
//   the single-pixel output port; busy drops in the cycle the last pixel issues.
// Reset (rst_n low, synchronous): pipeline emptied, format set to packed 4:2:2.
// The receiver cannot stall: each pixel is on out_pixel for one cycle with out_strobe.
// Depends on yrgb_pkg, yrgb_issue, yrgb_arith, yrgb_clamp.
module ycbcr_to_rgb_pixel_converter (
  input  logic                clk,
  input  logic                rst_n,
  // request channel
  input  logic                start,
  output logic                busy,
  input  yrgb_pkg::in_item_t  in_item,
  // pixel channel
  output logic                out_strobe,
  output yrgb_pkg::out_item_t out_pixel,
  // configuration
  input  logic                cfg_we,
  input  logic                cfg_wdata
);

  // Source format register; the issue stage latches it with each request,
  // so a write only affects requests taken afterwards.
  logic fmt_r;

  // Stage 1: register c, d, e for one pixel. Stages 2-3: products, sums.
  // Stage 4: clamp into the output register.
  yrgb_pkg::stage1_t s1;
  yrgb_pkg::stage3_t s3;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r <= yrgb_pkg::FMT_PACKED;
    end else if (cfg_we) begin
      fmt_r <= cfg_wdata;
    end
  end

  // Hold the request and advance through its pixels one per cycle
  yrgb_issue u_issue (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .fmt     (fmt_r),
    .in_item (in_item),
    .busy    (busy),
    .s1      (s1)
  );

  // Multiply by the BT.601 coefficients, then round and sum each component
  yrgb_arith u_arith (
    .clk   (clk),
    .rst_n (rst_n),
    .s1    (s1),
    .s3    (s3)
  );

  // Drop the fraction, clamp to 8 bits and present the pixel
  yrgb_clamp u_clamp (
    .clk    (clk),
    .rst_n  (rst_n),
    .s3     (s3),
    .strobe (out_strobe),
    .pixel  (out_pixel)
  );

endmodule
